[rtl/cvsa_pkg.sv]
// ============================================================================
// cvsa_pkg - shared types and constants for the sub-layer arg-min search
// Field widths, fixed-point positions, register indexes and sequencer states.
// ============================================================================
`default_nettype none

package cvsa_pkg;

    // Field and register widths
    localparam int COST_W  = 32;   // cost sample, Q16.16
    localparam int DEPTH_W = 25;   // depth, signed Q9.16
    localparam int E_W     = 48;   // energy, Q32.16
    localparam int CFG_W   = 32;   // configuration registers, Q8.24
    localparam int FRAC_W  = 16;   // fraction bits of depth, cost and energy
    localparam int WFRAC_W = 24;   // fraction bits of the Q8.24 weights

    // Packed stream words
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // Layer indexing
    localparam int MAX_LAYERS = 256;
    localparam int LAYER_W    = $clog2(MAX_LAYERS);
    localparam int LC_W       = $clog2(MAX_LAYERS + 1);

    // Datapath widths
    localparam int DIFF_W = DEPTH_W + 1;   // depth minus layer position
    localparam int MUL_W  = 32;            // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int DEN_W  = E_W + 1;       // parabola denominator
    localparam int OFF_W  = FRAC_W;        // sub-layer offset, up to one half
    localparam int DIV_STEPS = FRAC_W;     // one quotient bit per step

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_SCALE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_WEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] QUAD_SCALE_RST  = 32'h0000_0000;
    localparam logic [CFG_W-1:0] DATA_WEIGHT_RST = 32'h0100_0000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,   // wait for a request
        ST_SQ,     // square of depth minus layer
        ST_HI,     // upper square bits times quad_scale
        ST_LO,     // lower square bits times quad_scale
        ST_DW,     // cost times data_weight
        ST_SUM,    // form the layer energy
        ST_SEL,    // update minimum and neighbors
        ST_PICK,   // choose edge result or set up the parabola
        ST_CHK,    // decide whether to divide
        ST_DIV,    // wait on the divider
        ST_MH,     // upper magnitude bits times offset
        ST_ML,     // lower magnitude bits times offset
        ST_CORR,   // apply energy correction and offset
        ST_EMIT    // hand the result to the output register
    } state_t;

endpackage : cvsa_pkg

`default_nettype wire

[rtl/cvsa_mul.sv]
// ============================================================================
// cvsa_mul - shared unsigned multiplier
// One 32 by 32 product per cycle, registered at the output.
// ============================================================================
`default_nettype none

module cvsa_mul
    import cvsa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [MUL_W-1:0]  op_a,
    input  wire logic [MUL_W-1:0]  op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule : cvsa_mul

`default_nettype wire

[rtl/cvsa_div.sv]
// ============================================================================
// cvsa_div - restoring divider for the parabola offset
// Produces floor(num * 2^15 / den) for num <= den, one quotient bit a cycle.
// ============================================================================
`default_nettype none

module cvsa_div
    import cvsa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [E_W-1:0]    num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic      [OFF_W-1:0]  quot
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [OFF_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic             take;
    logic [REM_W-1:0] part;

    always_comb begin
        take = rem_reg >= REM_W'(den_reg);
        part = take ? (rem_reg - REM_W'(den_reg)) : rem_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: compare, subtract, shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {part[REM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[OFF_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule : cvsa_div

`default_nettype wire

[rtl/cost_volume_subpixel_argmin.sv]
// ============================================================================
// cost_volume_subpixel_argmin - parabolic sub-layer arg-min over a cost column
// Forms each layer's energy on one shared multiplier, tracks the minimum and
// its neighbors, and refines the winning layer by a parabola fit at pixel end.
// ============================================================================
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  --------------------------------------
//  s_       in   s_tvalid/s_tready   s_tdata: cost_sample, current_depth;
//                                    s_tlast: last sample of the pixel
//  m_       out  m_tvalid/m_tready   m_tdata: refined_depth, match_cost
//  cfg_     in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
//  Steps: from request to the next ready, a sample makes four products that
//  go one after another through the shared 32x32 multiplier, then forms its
//  energy and updates the minimum. A last sample then adds a pick and an emit
//  step when an edge layer wins; otherwise a check, two multiplier passes for
//  the energy correction, a correction step and the emit, with the bit-serial
//  divider run between the check and those passes when the parabola is fit.
//  Reset: aresetn is synchronous, active low; it clears the sequencer, the
//  layer count and the output valid, and loads the register reset values.
//  Stalls: s_tready is high only between samples. A result waits in the
//  output register while the next pixel streams in; the sequencer holds in
//  its emit step only if a second result is ready before the first is taken.
// ============================================================================
`default_nettype none

module cost_volume_subpixel_argmin
    import cvsa_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,

    // sample stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] cost_sample, [56:32] current_depth
    input  wire logic                   s_tlast,   // last_sample

    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_DATA_W-1:0]  m_tdata    // [24:0] refined_depth, [72:25] match_cost
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] quad_scale_reg;
    logic [CFG_W-1:0] data_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_scale_reg  <= QUAD_SCALE_RST;
            data_weight_reg <= DATA_WEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_QUAD_SCALE:  quad_scale_reg  <= cfg_wdata;
                REG_DATA_WEIGHT: data_weight_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic [LC_W-1:0] lc_reg, lc_next;
    logic            m_valid_reg, m_valid_next;

    logic [DEPTH_W-1:0]    held_depth_reg;
    logic [LAYER_W-1:0]    idx_reg;
    logic [DIFF_W-1:0]     absdiff_reg;
    logic [COST_W-1:0]     cost_reg;
    logic                  last_reg;
    logic [WFRAC_W-1:0]    sq_lo_reg;
    logic [PROD_W-1:0]     acc_reg;
    logic [42:0]           t1_reg;        // quadratic term, Q.16
    logic [E_W-1:0]        e_reg;
    logic [E_W-1:0]        best_reg;
    logic [LAYER_W-1:0]    best_layer_reg;
    logic [E_W-1:0]        left_reg;
    logic [E_W-1:0]        right_reg;
    logic [E_W-1:0]        prior_reg;
    logic [E_W-1:0]        second_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [E_W-1:0]        mag_reg;
    logic                  neg_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [DEPTH_W-1:0]    res_depth_reg;
    logic [E_W-1:0]        res_energy_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // shared units
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic              div_start;
    logic              div_done;
    logic [OFF_W-1:0]  div_quot;

    cvsa_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    cvsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mag_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  out_free;
    logic [DEPTH_W-1:0]    depth_sel;
    logic [LAYER_W-1:0]    idx_w;
    logic [DIFF_W-1:0]     diff_w;
    logic [58:0]           t1_sum;
    logic [E_W-1:0]        e_sum;
    logic                  upd_min;
    logic                  pick_direct;
    logic [DEN_W-1:0]      sum_ac;
    logic [DEN_W-1:0]      twob;
    logic                  div_go;
    logic [PROD_W-1:0]     corr_full;
    logic [E_W-1:0]        corr;
    logic [DEPTH_W-1:0]    base_depth;

    always_comb begin
        accept   = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;

        // take a new depth on the first sample of a pixel
        depth_sel = (lc_reg == '0) ? s_tdata[COST_W +: DEPTH_W] : held_depth_reg;
        // saturate the layer index at the last layer
        idx_w = (lc_reg >= LC_W'(MAX_LAYERS - 1)) ? LAYER_W'(MAX_LAYERS - 1)
                                                  : lc_reg[LAYER_W-1:0];
        diff_w = {depth_sel[DEPTH_W-1], depth_sel}
               - DIFF_W'({idx_w, {FRAC_W{1'b0}}});

        // quadratic term: (hi*q + (lo*q >> 24)) >> 16
        t1_sum = acc_reg[58:0] + 59'(prod[PROD_W-1:WFRAC_W]);
        // both terms stay well below 2^47, so the sum never saturates
        e_sum  = E_W'(t1_reg) + E_W'(prod[PROD_W-1:WFRAC_W]);

        upd_min     = (lc_reg >= LC_W'(2)) && (prior_reg < best_reg);
        pick_direct = (e_reg < best_reg) || (best_layer_reg == '0);

        sum_ac = DEN_W'(left_reg) + DEN_W'(right_reg);
        twob   = {best_reg, 1'b0};

        div_go = (den_reg != '0) && (DEN_W'(mag_reg) <= den_reg);

        // correction = (mag * off) >> 18, from two partial products
        corr_full  = {acc_reg[MUL_W-1:0], {MUL_W{1'b0}}} + prod;
        corr       = E_W'(corr_full[PROD_W-1:18]);
        base_depth = DEPTH_W'({best_layer_reg, {FRAC_W{1'b0}}});
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SQ;
            ST_SQ:   state_next = ST_HI;
            ST_HI:   state_next = ST_LO;
            ST_LO:   state_next = ST_DW;
            ST_DW:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_SEL;
            ST_SEL:  state_next = last_reg ? ST_PICK : ST_IDLE;
            ST_PICK: state_next = pick_direct ? ST_EMIT : ST_CHK;
            ST_CHK:  state_next = div_go ? ST_DIV : ST_MH;
            ST_DIV:  if (div_done) state_next = ST_MH;
            ST_MH:   state_next = ST_ML;
            ST_ML:   state_next = ST_CORR;
            ST_CORR: state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (ready, multiplier operands, divider start)
    // ------------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SQ: begin
                mul_a = MUL_W'(absdiff_reg);
                mul_b = MUL_W'(absdiff_reg);
            end
            ST_HI: begin
                mul_a = MUL_W'(prod[2*DIFF_W-3:WFRAC_W]);
                mul_b = quad_scale_reg;
            end
            ST_LO: begin
                mul_a = MUL_W'(sq_lo_reg);
                mul_b = quad_scale_reg;
            end
            ST_DW: begin
                mul_a = cost_reg;
                mul_b = data_weight_reg;
            end
            ST_CHK:  div_start = div_go;
            ST_MH: begin
                mul_a = MUL_W'(mag_reg[E_W-1:MUL_W]);
                mul_b = MUL_W'(off_reg);
            end
            ST_ML: begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = MUL_W'(off_reg);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_comb begin
        lc_next = lc_reg;
        if (state_reg == ST_SEL) begin
            if (last_reg) begin
                lc_next = '0;
            end else if (lc_reg < LC_W'(MAX_LAYERS)) begin
                lc_next = lc_reg + 1'b1;
            end
        end

        if (state_reg == ST_EMIT && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lc_reg      <= lc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    held_depth_reg <= depth_sel;
                    idx_reg        <= idx_w;
                    absdiff_reg    <= diff_w[DIFF_W-1] ? (~diff_w + 1'b1) : diff_w;
                    cost_reg       <= s_tdata[COST_W-1:0];
                    last_reg       <= s_tlast;
                end
            end
            ST_HI: sq_lo_reg <= prod[WFRAC_W-1:0];
            ST_LO: acc_reg   <= prod;
            ST_DW: t1_reg    <= t1_sum[58:FRAC_W];
            ST_SUM: e_reg    <= e_sum;
            ST_SEL: begin
                // the minimum runs over the inner layers; the newest energy
                // becomes the right neighbor of a new minimum
                if (lc_reg == '0) begin
                    best_reg       <= e_reg;
                    best_layer_reg <= '0;
                end else if (upd_min) begin
                    best_reg       <= prior_reg;
                    best_layer_reg <= idx_reg - 1'b1;
                    left_reg       <= second_reg;
                    right_reg      <= e_reg;
                end
                second_reg <= prior_reg;
                prior_reg  <= e_reg;
            end
            ST_PICK: begin
                if (e_reg < best_reg) begin
                    // last layer wins outright
                    res_depth_reg  <= DEPTH_W'({idx_reg, {FRAC_W{1'b0}}});
                    res_energy_reg <= e_reg;
                end else if (best_layer_reg == '0) begin
                    // first layer still holds the minimum
                    res_depth_reg  <= '0;
                    res_energy_reg <= best_reg;
                end
                den_reg <= (sum_ac > twob) ? (sum_ac - twob) : '0;
                neg_reg <= right_reg > left_reg;
                mag_reg <= (right_reg > left_reg) ? (right_reg - left_reg)
                                                  : (left_reg - right_reg);
            end
            ST_CHK: begin
                // flat or out-of-range fit: no offset, energy stays at the minimum
                if (!div_go) off_reg <= '0;
            end
            ST_DIV: begin
                if (div_done) off_reg <= div_quot;
            end
            ST_ML: acc_reg <= prod;
            ST_CORR: begin
                res_energy_reg <= (best_reg > corr) ? (best_reg - corr) : '0;
                res_depth_reg  <= neg_reg ? (base_depth - DEPTH_W'(off_reg))
                                          : (base_depth + DEPTH_W'(off_reg));
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_data_reg <= OUT_DATA_W'({res_energy_reg, res_depth_reg});
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_lc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lc_reg <= LC_W'(MAX_LAYERS))
        else $error("layer count ran past its saturation point");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL && last_reg) |=> (lc_reg == '0))
        else $error("layer count not cleared after a last sample");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_off_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MH) |-> (off_reg <= OFF_W'(1 << (OFF_W - 1))))
        else $error("sub-layer offset exceeds one half");

endmodule : cost_volume_subpixel_argmin

`default_nettype wire

[dv/testbench.sv]
// ============================================================================
// testbench - self-checking bench for cost_volume_subpixel_argmin
// Streams pixel cost columns through the sample channel in random bursts and
// predicts each pixel's refined depth and match cost in a local model. The
// model is updated on every accepted request. Each result taken from the
// result channel is checked against the oldest prediction. Weight registers
// change only while the block is drained.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cvsa_pkg::*;

    localparam int          DRAIN_CYCLES = 60;     // settle time, longer than the worst pixel end
    localparam int          HOLD_CYCLES  = 600;    // long receiver hold-off
    localparam int unsigned HOLD_AFTER   = 150;    // samples taken before the hold-off
    localparam logic [63:0] E_MAX        = (64'd1 << E_W) - 64'd1;

    typedef struct {
        logic [COST_W-1:0]         cost;
        logic signed [DEPTH_W-1:0] depth;
        logic                      last;
    } sample_t;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [E_W-1:0]     energy;
    } pixel_result_t;

    // DUT ports, inputs all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [31:0] cost_sample, [56:32] current_depth
    logic                  s_tlast   = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [24:0] refined_depth, [72:25] match_cost

    cost_volume_subpixel_argmin dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Search model: weights, per-pixel tracking state
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]          quad_scale_r  = QUAD_SCALE_RST;
    logic [CFG_W-1:0]          data_weight_r = DATA_WEIGHT_RST;
    int unsigned               layers_seen   = 0;
    logic signed [DEPTH_W-1:0] pixel_depth   = '0;
    logic [E_W-1:0]            min_e         = '0;
    logic [LAYER_W-1:0]        min_layer     = '0;
    logic [E_W-1:0]            left_e        = '0;   // layer before the minimum
    logic [E_W-1:0]            right_e       = '0;   // layer after the minimum
    logic [E_W-1:0]            prev_e        = '0;
    logic [E_W-1:0]            prev2_e       = '0;

    sample_t       sample_q[$];          // requests waiting for the driver
    pixel_result_t pixel_results_q[$];   // predicted results, oldest first
    int unsigned   mismatches = 0;

    // Energy of layer k: quad_scale * (depth - k)^2 + data_weight * cost,
    // both terms floored to Q.16, sum clamped at the 48-bit ceiling.
    function automatic logic [E_W-1:0] layer_energy_of(int unsigned k,
                                                       logic [COST_W-1:0] cost);
        longint      diff;
        logic [63:0] sq;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] total;
        diff  = longint'(pixel_depth) - (longint'(k) << FRAC_W);
        sq    = diff * diff;
        hi    = sq >> WFRAC_W;
        lo    = sq & 64'hFF_FFFF;
        t1    = (hi * quad_scale_r + ((lo * quad_scale_r) >> WFRAC_W)) >> FRAC_W;
        t2    = (64'(cost) * data_weight_r) >> WFRAC_W;
        total = t1 + t2;
        return (total > E_MAX) ? E_MAX[E_W-1:0] : total[E_W-1:0];
    endfunction

    // Fold one accepted sample into the pixel state; on the last sample of
    // the pixel, produce the refined depth and energy.
    function automatic void argmin_step(input sample_t s, output bit has_result,
                                        output pixel_result_t res);
        int unsigned idx;
        logic [E_W-1:0] e;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] sum;
        logic [63:0] twob;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] off;
        logic [63:0] corr;
        logic [63:0] energy;
        logic [79:0] wide;
        bit          neg;
        longint      dep;
        has_result = 1'b0;
        res        = '{default: '0};
        idx = (layers_seen < MAX_LAYERS) ? layers_seen : MAX_LAYERS - 1;
        if (layers_seen == 0) pixel_depth = s.depth;
        e = layer_energy_of(idx, s.cost);

        // the layer before this one is now final: it may take the minimum
        if (layers_seen == 0) begin
            min_e     = e;
            min_layer = '0;
        end else if (layers_seen >= 2 && prev_e < min_e) begin
            min_e     = prev_e;
            min_layer = LAYER_W'(idx - 1);
            left_e    = prev2_e;
            right_e   = e;
        end
        prev2_e = prev_e;
        prev_e  = e;

        if (!s.last) begin
            if (layers_seen < MAX_LAYERS) layers_seen++;
            return;
        end

        has_result = 1'b1;
        if (e < min_e) begin
            // last layer wins outright
            dep    = longint'(idx) << FRAC_W;
            energy = 64'(e);
        end else if (min_layer == 0) begin
            dep    = 0;
            energy = 64'(min_e);
        end else begin
            // vertex of the parabola through left, minimum and right
            a    = 64'(left_e);
            b    = 64'(min_e);
            c    = 64'(right_e);
            sum  = a + c;
            twob = b << 1;
            den  = (sum > twob) ? sum - twob : 64'd0;
            neg  = c > a;
            mag  = neg ? c - a : a - c;
            off  = 64'd0;
            if (den != 0 && mag <= den) begin
                wide = 80'(mag) << 15;
                off  = 64'(wide / 80'(den));
            end
            wide   = 80'(mag) * 80'(off);
            corr   = 64'(wide >> 18);
            energy = (b > corr) ? b - corr : 64'd0;
            dep    = (longint'(min_layer) << FRAC_W) + (neg ? -longint'(off) : longint'(off));
        end
        res.depth   = dep[DEPTH_W-1:0];
        res.energy  = energy[E_W-1:0];
        layers_seen = 0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t  mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: bursts of random length with random gaps. A request
    // holds on the bus until it is taken; the prediction is made at the edge
    // that accepts it.
    // ------------------------------------------------------------------------
    int unsigned burst_left       = 0;
    int unsigned gap_left         = 0;
    int unsigned samples_accepted = 0;
    sample_t     on_bus;

    always @(posedge aclk) begin : sample_driver
        logic          drive;
        bit            has;
        pixel_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                argmin_step(on_bus, has, res);
                if (has) pixel_results_q.push_back(res);
                samples_accepted <= samples_accepted + 1;
            end
            // not holding a request: advance the burst pattern
            if (!s_tvalid || s_tready) begin
                drive = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (sample_q.size() != 0) begin
                    on_bus = sample_q.pop_front();
                    drive  = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
                s_tvalid <= drive;
                if (drive) begin
                    s_tdata <= {{(IN_DATA_W - COST_W - DEPTH_W){1'b0}}, on_bus.depth, on_bus.cost};
                    s_tlast <= on_bus.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: switch among stall modes every so often; once, hold off
    // for a long stretch so the output register fills and the block stalls
    // its sample input while the driver keeps offering.
    // ------------------------------------------------------------------------
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode   = 0;
    bit          held_once = 1'b0;

    always @(posedge aclk) begin : result_sink
        if (!held_once && samples_accepted >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_results_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            end else begin
                want = pixel_results_q.pop_front();
                if (m_tdata[DEPTH_W-1:0] != want.depth)
                    report_mismatch("refined_depth", 64'(m_tdata[DEPTH_W-1:0]),
                                    64'(want.depth));
                if (m_tdata[DEPTH_W +: E_W] != want.energy)
                    report_mismatch("match_cost", 64'(m_tdata[DEPTH_W +: E_W]),
                                    64'(want.energy));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------------
    task automatic add_sample(logic [COST_W-1:0] cost, logic [DEPTH_W-1:0] depth, logic last);
        sample_t s;
        s.cost  = cost;
        s.depth = depth;
        s.last  = last;
        sample_q.push_back(s);
    endtask

    // Write one weight register and mirror it into the model.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_QUAD_SCALE:  quad_scale_r  = value;
            REG_DATA_WEIGHT: data_weight_r = value;
            default: ;
        endcase
    endtask

    // Hold until every request is taken and every result is back, then let
    // the block settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || pixel_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_weights(logic [CFG_W-1:0] quad, logic [CFG_W-1:0] weight);
        write_reg(REG_QUAD_SCALE, quad);
        write_reg(REG_DATA_WEIGHT, weight);
        @(negedge aclk);
    endtask

    // Queue whole pixels until about `budget` samples. About half the columns are bowl
    // shaped so the minimum lands inside and the parabola fit runs; the rest
    // are raw noise or low-valued columns full of ties.
    task automatic queue_pixels(int budget, bit with_long);
        int                  made;
        int                  len;
        int                  center;
        int                  kind;
        int                  shape;
        int                  k;
        logic [31:0]         sq;
        logic [31:0]         scale;
        logic [COST_W-1:0]   cost;
        logic [DEPTH_W-1:0]  depth;
        made = 0;
        while (made < budget || with_long) begin
            if (with_long) begin
                // runs past MAX_LAYERS so the layer index saturates
                len       = MAX_LAYERS + 4;
                with_long = 1'b0;
                depth     = DEPTH_W'($urandom_range(0, (MAX_LAYERS - 1) << FRAC_W));
                shape     = 0;
            end else begin
                kind = $urandom_range(0, 19);
                if (kind < 2)       len = $urandom_range(1, 2);
                else if (kind < 16) len = $urandom_range(3, 10);
                else                len = $urandom_range(11, 40);
                if ($urandom_range(0, 4) == 0) depth = DEPTH_W'($urandom);
                else                           depth = DEPTH_W'($urandom_range(0, len * 65536 - 1));
                shape = $urandom_range(0, 3);
            end
            center = $urandom_range(0, len - 1);
            scale  = $urandom_range(1, 1 << 16);
            for (k = 0; k < len; k++) begin
                case (shape)
                    0, 1: begin
                        sq   = (k - center) * (k - center);
                        cost = sq * scale + $urandom_range(0, scale);
                    end
                    2:       cost = $urandom;
                    default: cost = $urandom_range(0, 15);
                endcase
                if ($urandom_range(0, 63) == 0) cost = '1;
                // only the first sample's depth counts; later ones are noise
                add_sample(cost, (k == 0) ? depth : DEPTH_W'($urandom), k == len - 1);
            end
            made += len;
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed columns at reset weights, where energy equals cost.
        add_sample('1, 25'h0FF_FFFF, 1'b1);              // lone sample, largest depth
        add_sample('0, 25'h100_0000, 1'b1);              // lone sample, most negative depth
        add_sample(32'd100, 25'h001_0000, 1'b0);         // two samples, second lower
        add_sample(32'd50, 25'h000_0000, 1'b1);
        add_sample(32'd7, 25'h000_8000, 1'b0);           // two samples, tie keeps layer 0
        add_sample(32'd7, 25'h000_0000, 1'b1);
        add_sample(32'd30, 25'h002_0000, 1'b0);          // falling column, last layer wins
        add_sample(32'd20, 25'h000_0000, 1'b0);
        add_sample(32'd10, 25'h000_0000, 1'b1);
        add_sample(32'd5, 25'h000_4000, 1'b0);           // first layer stays minimum
        add_sample(32'd9, 25'h000_0000, 1'b0);
        add_sample(32'd9, 25'h000_0000, 1'b0);
        add_sample(32'd9, 25'h000_0000, 1'b1);
        add_sample(32'd40, 25'h001_8000, 1'b0);          // interior minimum, depth latched
        add_sample(32'd10, 25'h1AA_AAAA, 1'b0);
        add_sample(32'd25, 25'h055_5555, 1'b0);
        add_sample(32'd60, 25'h1FF_FFFF, 1'b1);
        add_sample(32'd8, 25'h000_0000, 1'b0);           // flat column, no strict minimum
        add_sample(32'd8, 25'h000_0000, 1'b0);
        add_sample(32'd8, 25'h000_0000, 1'b1);
        add_sample(32'd50, 25'h002_0000, 1'b0);          // minimum next to the last layer
        add_sample(32'd40, 25'h000_0000, 1'b0);
        add_sample(32'd10, 25'h000_0000, 1'b0);
        add_sample(32'd20, 25'h000_0000, 1'b1);
        wait_drained();

        // Random columns over several weight settings, extremes included.
        set_weights(32'h0100_0000, 32'h0100_0000);
        queue_pixels(250, 1'b0);
        wait_drained();

        set_weights(32'hFFFF_FFFF, 32'h0000_0000);
        queue_pixels(150, 1'b0);
        wait_drained();

        set_weights(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pixels(150, 1'b0);
        wait_drained();

        set_weights($urandom, $urandom);
        queue_pixels(100, 1'b1);
        wait_drained();

        set_weights($urandom_range(0, 1 << 22), $urandom);
        queue_pixels(200, 1'b0);
        wait_drained();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #4_800_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule : testbench

`default_nettype wire
